FILE: design/frft_pkg.sv
// shared types and constants for the frame fragment reassembly tracker
// no dependencies; used by frft_ctrl, frft_dp and the top level
package frft_pkg;

    // item field widths
    localparam int ID_W     = 8;
    localparam int SEQ_W    = 8;
    localparam int OFFSET_W = 19;

    // reset values of slot and screen state
    localparam logic [SEQ_W-1:0] SEQ_RESET = 8'd254;
    localparam logic [ID_W-1:0]  ID_RESET  = 8'd255;

    // header bytes stripped from each packet before the payload
    localparam int HEADER_BYTES = 4;

    // verdict codes
    localparam logic [1:0] VERDICT_ACCEPT = 2'd0;
    localparam logic [1:0] VERDICT_LATE   = 2'd1;
    localparam logic [1:0] VERDICT_SAME   = 2'd2;

    // one fragment header
    typedef struct packed {
        logic [ID_W-1:0]  frame_id;
        logic             screen_top;
        logic             last_fragment;
        logic [SEQ_W-1:0] seq_num;
    } t_in_item;

    // one result
    typedef struct packed {
        logic [1:0]          verdict;
        logic [OFFSET_W-1:0] write_offset;
        logic                frame_done;
        logic [ID_W-1:0]     last_good_id;
        logic                slot_reset;
    } t_out_item;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_MARK1,
        ST_MARK2,
        ST_MARK3
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic clear;
        logic load;
        logic read;
        logic eval;
        logic mark;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clear_last;
        logic frame_done;
    } t_dp_status;

endpackage

FILE: design/frft_ctrl.sv
// sequencer for the reassembly tracker: clearing pass, read, evaluate, mark
// depends on frft_pkg
module frft_ctrl
    import frft_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       busy
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_status.clear_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (start) n_state = ST_READ;
            end
            ST_READ:  n_state = ST_EVAL;
            ST_EVAL: begin
                n_state = i_status.frame_done ? ST_MARK1 : ST_IDLE;
            end
            ST_MARK1: n_state = ST_MARK2;
            ST_MARK2: n_state = ST_MARK3;
            ST_MARK3: n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        case (r_state)
            ST_CLEAR: o_cmd.clear = 1'b1;
            ST_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            ST_READ:  o_cmd.read = 1'b1;
            ST_EVAL:  o_cmd.eval = 1'b1;
            ST_MARK1: o_cmd.mark = 1'b1;
            ST_MARK2: o_cmd.mark = 1'b1;
            ST_MARK3: o_cmd.mark = 1'b1;
            default:  o_cmd = '0;
        endcase
    end

endmodule

FILE: design/frft_dp.sv
// datapath of the reassembly tracker: slot memories, per-screen last ids,
// completion check and result register; depends on frft_pkg
module frft_dp
    import frft_pkg::*;
#(
    parameter int FRAME_SLOTS         = 256,
    parameter int FRAGMENTS_PER_FRAME = 256,
    parameter int PACKET_BYTES        = 1448
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  t_in_item   i_item,
    output t_dp_status o_status,
    output logic       o_valid,
    output t_out_item  o_result
);

    localparam int SLOT_W     = $clog2(FRAME_SLOTS);
    localparam int ADDR_W     = SLOT_W + 1;
    localparam int MEM_DEPTH  = 2 ** ADDR_W;
    localparam int FRAG_BYTES = PACKET_BYTES - HEADER_BYTES;
    localparam int PROD_W     = SEQ_W + 17;

    typedef struct packed {
        logic [FRAGMENTS_PER_FRAME-1:0] seen;
        logic [SEQ_W-1:0]               final_seq;
        logic                           pending;
    } t_slot_row;

    // slot state memories, one row per screen and slot
    t_slot_row row_mem  [MEM_DEPTH];
    logic      comp_mem [MEM_DEPTH];

    t_in_item         r_item;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [SLOT_W-1:0] r_mark;
    logic [ID_W-1:0]   r_last_id [2];
    t_slot_row         r_row_rd;
    logic              r_comp_rd;
    t_out_item         r_result;
    logic              r_valid;

    // frame id to slot, a constant table
    logic [SLOT_W-1:0] w_slot_lut [2 ** ID_W];
    for (genvar g = 0; g < 2 ** ID_W; g++) begin : g_slot_lut
        assign w_slot_lut[g] = SLOT_W'(g % FRAME_SLOTS);
    end

    // previous slot with wrap
    function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
        slot_dec = (s == '0) ? SLOT_W'(FRAME_SLOTS - 1) : s - 1'b1;
    endfunction

    logic [ID_W-1:0]                w_cur_id;
    logic [ID_W-1:0]                w_diff;
    logic                           w_discard;
    logic [FRAGMENTS_PER_FRAME-1:0] w_base_seen;
    logic [SEQ_W-1:0]               w_base_final;
    logic                           w_base_pend;
    t_slot_row                      w_new_row;
    logic [FRAGMENTS_PER_FRAME-1:0] w_below;
    logic                           w_fin_ok;
    logic                           w_all_ok;
    logic                           w_done;
    logic [PROD_W-1:0]              w_prod;
    t_out_item                      w_result;

    // discard test against last complete id
    assign w_cur_id  = r_last_id[r_item.screen_top];
    assign w_diff    = r_item.frame_id - w_cur_id;
    assign w_discard = (w_diff == '0) || w_diff[ID_W-1];

    // slot update and completion check
    always_comb begin
        w_base_seen  = r_comp_rd ? '0 : r_row_rd.seen;
        w_base_final = r_comp_rd ? SEQ_RESET : r_row_rd.final_seq;
        w_base_pend  = r_comp_rd ? 1'b0 : r_row_rd.pending;
        for (int i = 0; i < FRAGMENTS_PER_FRAME; i++) begin
            w_new_row.seen[i] = w_base_seen[i] | ({1'b0, r_item.seq_num} == 9'(i));
        end
        w_new_row.final_seq = r_item.last_fragment ? r_item.seq_num : w_base_final;
        w_new_row.pending   = r_item.last_fragment | w_base_pend;
        for (int i = 0; i < FRAGMENTS_PER_FRAME; i++) begin
            w_below[i] = 9'(i) < {1'b0, w_new_row.final_seq};
        end
        w_fin_ok = {1'b0, w_new_row.final_seq} <= 9'(FRAGMENTS_PER_FRAME);
        w_all_ok = &(w_new_row.seen | ~w_below);
        w_done   = !w_discard && w_new_row.pending && w_fin_ok && w_all_ok;
    end

    // payload offset
    assign w_prod = PROD_W'(r_item.seq_num) * PROD_W'(FRAG_BYTES);

    // result fields
    always_comb begin
        w_result = '0;
        if (w_discard) begin
            w_result.verdict      = (w_diff == '0) ? VERDICT_SAME : VERDICT_LATE;
            w_result.last_good_id = w_cur_id;
        end else begin
            w_result.verdict      = VERDICT_ACCEPT;
            w_result.write_offset = w_prod[OFFSET_W-1:0];
            w_result.frame_done   = w_done;
            w_result.last_good_id = w_done ? r_item.frame_id : w_cur_id;
            w_result.slot_reset   = r_comp_rd;
        end
    end

    // row memory write and registered read
    logic              w_row_we;
    logic [ADDR_W-1:0] w_row_wa;
    t_slot_row         w_row_wd;

    always_comb begin
        w_row_we = 1'b0;
        w_row_wa = r_addr;
        w_row_wd = w_new_row;
        if (i_cmd.clear) begin
            w_row_we           = 1'b1;
            w_row_wa           = r_clr_addr;
            w_row_wd.seen      = '0;
            w_row_wd.final_seq = SEQ_RESET;
            w_row_wd.pending   = 1'b0;
        end else if (i_cmd.eval && !w_discard) begin
            w_row_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_row_we) row_mem[w_row_wa] <= w_row_wd;
        if (i_cmd.read) r_row_rd <= row_mem[r_addr];
    end

    // complete mark memory write and registered read
    logic              w_comp_we;
    logic [ADDR_W-1:0] w_comp_wa;
    logic              w_comp_wd;

    always_comb begin
        w_comp_we = 1'b0;
        w_comp_wa = r_addr;
        w_comp_wd = w_done;
        if (i_cmd.clear) begin
            w_comp_we = 1'b1;
            w_comp_wa = r_clr_addr;
            w_comp_wd = 1'b0;
        end else if (i_cmd.mark) begin
            w_comp_we = 1'b1;
            w_comp_wa = {r_item.screen_top, r_mark};
            w_comp_wd = 1'b1;
        end else if (i_cmd.eval && !w_discard) begin
            w_comp_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_comp_we) comp_mem[w_comp_wa] <= w_comp_wd;
        if (i_cmd.read) r_comp_rd <= comp_mem[r_addr];
    end

    // input item and slot address
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
            r_addr <= {i_item.screen_top, w_slot_lut[i_item.frame_id]};
        end
    end

    // previous-slot pointer for completion marks
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_mark <= slot_dec(r_addr[SLOT_W-1:0]);
        end else if (i_cmd.mark) begin
            r_mark <= slot_dec(r_mark);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) r_result <= w_result;
    end

    // control state: clearing address, last ids, result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr   <= '0;
            r_last_id[0] <= ID_RESET;
            r_last_id[1] <= ID_RESET;
            r_valid      <= 1'b0;
        end else begin
            r_valid <= i_cmd.eval;
            if (i_cmd.clear) r_clr_addr <= r_clr_addr + 1'b1;
            if (i_cmd.eval && w_done) r_last_id[r_item.screen_top] <= r_item.frame_id;
        end
    end

    assign o_status.clear_last = &r_clr_addr;
    assign o_status.frame_done = w_done;
    assign o_valid             = r_valid;
    assign o_result            = r_result;

endmodule

FILE: design/frame_fragment_reassembly_tracker.sv
// top level of the frame fragment reassembly tracker: controller plus datapath
// depends on frft_pkg, frft_ctrl, frft_dp
// start taken in idle loads an item, which is read, then evaluated into the result
//   register; busy is high until idle again, so no new item is taken before the last
//   is through; an item that completes a frame adds three single-port writes that
//   mark the previous slots complete; reset is synchronous, with a clearing pass over
//   all 2**(clog2(FRAME_SLOTS)+1) rows at busy high; the receiver cannot stall results
module frame_fragment_reassembly_tracker
    import frft_pkg::*;
#(
    parameter int FRAME_SLOTS         = 256,
    parameter int FRAGMENTS_PER_FRAME = 256,
    parameter int PACKET_BYTES        = 1448
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_valid,
    output t_out_item o_result
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // sequencer
    frft_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .busy     (busy)
    );

    // slot state and result datapath
    frft_dp #(
        .FRAME_SLOTS         (FRAME_SLOTS),
        .FRAGMENTS_PER_FRAME (FRAGMENTS_PER_FRAME),
        .PACKET_BYTES        (PACKET_BYTES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_item   (i_item),
        .o_status (w_status),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule
